[rtl/core/row_skew_realigner_top_defines.svh]
// Assertion macros shared by the row skew realigner RTL.
// Depends on nothing; files that check their own logic include this header.
`ifndef ROW_SKEW_REALIGNER_TOP_DEFINES_SVH
`define ROW_SKEW_REALIGNER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check on every clock edge outside of reset.
`define RSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check on every clock edge, reset included.
`define RSR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RSR_ASSERT(lbl, prop, msg)
`define RSR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[rtl/core/rsr_pkg.sv]
// Shared types and constants for the row skew realigner.
// Used by rsr_out_fifo and row_skew_realigner_top; depends on nothing.
package rsr_pkg;

  localparam int PIX_W = 8;
  localparam int COL_W = 9;

  localparam logic [COL_W-1:0] ROW_WIDTH_RESET = 9'd188;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [COL_W-1:0] col_t;

  // One result transaction on the output channel.
  typedef struct packed {
    pix_t pixel;
    logic row_end;
    logic shifted;
  } res_t;

  // Side information that travels with a pending line buffer read.
  typedef struct packed {
    logic zero;
    logic row_end;
    logic shifted;
  } rd_meta_t;

endpackage

[rtl/core/rsr_line_buf.sv]
// Double row buffer: one write port and one read port with registered read data.
// Depends on nothing; instantiated by row_skew_realigner_top.
module rsr_line_buf #(
  parameter int DEPTH  = 512,
  parameter int ADDR_W = 9,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/rsr_out_fifo.sv]
// Two-entry result queue that decouples the output channel from the datapath.
// Depends on rsr_pkg; instantiated by row_skew_realigner_top.
module rsr_out_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rsr_pkg::res_t push_data,
  input  logic          pop,
  output logic          valid,
  output rsr_pkg::res_t data,
  output logic [1:0]    count
);

  rsr_pkg::res_t entry_r [2];
  logic          wr_ptr_r;
  logic          wr_ptr_nxt;
  logic          rd_ptr_r;
  logic          rd_ptr_nxt;
  logic [1:0]    cnt_r;
  logic [1:0]    cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign valid = (cnt_r != 2'd0);
  assign data  = entry_r[rd_ptr_r];
  assign count = cnt_r;

endmodule

[rtl/core/row_skew_realigner_top.sv]
// Each result is registered after its read, then queued in the output FIFO.
// Throughput: one input transaction per cycle; the line buffer has one write and
// one read port, and each transaction uses at most one of each.
// Input stalls while two results are pending and none leaves in that cycle.
// Reset clears all control state and the row width to 188; the row buffer is not cleared.
`include "row_skew_realigner_top_defines.svh"

module row_skew_realigner_top #(
  parameter int MAX_ROW_WIDTH = 256
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [rsr_pkg::COL_W-1:0] cfg_row_width,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [rsr_pkg::PIX_W-1:0] in_pixel_value,
  input  logic                    in_drain,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [rsr_pkg::PIX_W-1:0] out_pixel,
  output logic                    out_row_end,
  output logic                    out_row_was_shifted
);

  localparam int DEPTH     = 2 * MAX_ROW_WIDTH;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int WLAST_MAX = (MAX_ROW_WIDTH > 512 ? 512 : MAX_ROW_WIDTH) - 1;

  rsr_pkg::col_t     row_width_r, row_width_nxt;
  rsr_pkg::col_t     wr_col_r, wr_col_nxt;
  rsr_pkg::col_t     rd_col_r, rd_col_nxt;
  rsr_pkg::col_t     lnz_r, lnz_nxt;
  logic              found_r, found_nxt;
  rsr_pkg::col_t     shift_r, shift_nxt;
  logic              bank_r, bank_nxt;
  logic              held_r, held_nxt;
  logic              s1_v_r, s1_v_nxt;
  rsr_pkg::rd_meta_t s1_meta_r;

  rsr_pkg::col_t     wlast;
  rsr_pkg::col_t     rd_col_sub;
  rsr_pkg::col_t     shift_calc;
  logic              acc;
  logic              res_hit;
  logic              rd_last;
  logic              rd_zero;
  logic              rd_en;
  logic              wr_en;
  logic              wr_last;
  logic              pix_nz;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  rsr_pkg::pix_t     rd_data;

  rsr_pkg::res_t     push_data;
  rsr_pkg::res_t     fifo_data;
  logic [1:0]        fifo_cnt;
  logic [1:0]        occ_sum;
  logic              pop;

  // Last column of a row, from the width clamped to [2, MAX_ROW_WIDTH].
  always_comb begin
    if (row_width_r < 9'd2) begin
      wlast = 9'd1;
    end else if (32'(row_width_r) > 32'(MAX_ROW_WIDTH)) begin
      wlast = 9'(WLAST_MAX);
    end else begin
      wlast = row_width_r - 9'd1;
    end
  end

  always_comb begin
    acc     = in_valid & in_ready;
    res_hit = acc & held_r;

    rd_last    = (rd_col_r >= wlast);
    rd_zero    = (rd_col_r < shift_r);
    rd_col_sub = rd_col_r - shift_r;
    rd_en      = res_hit & ~rd_zero;
    // Read from the bank that is not being written.
    rd_addr    = ADDR_W'(rd_col_sub) + (bank_r ? '0 : ADDR_W'(MAX_ROW_WIDTH));

    wr_en   = acc & ~in_drain;
    wr_addr = ADDR_W'(wr_col_r) + (bank_r ? ADDR_W'(MAX_ROW_WIDTH) : '0);
    wr_last = (wr_col_r >= wlast);
    pix_nz  = (in_pixel_value != '0);

    // A nonzero pixel in the last column means no shift.
    if (!pix_nz && found_r && lnz_r != '0 && lnz_r < wr_col_r) begin
      shift_calc = wr_col_r - lnz_r;
    end else begin
      shift_calc = '0;
    end
  end

  always_comb begin
    row_width_nxt = (cfg_valid && cfg_ready) ? cfg_row_width : row_width_r;
    wr_col_nxt    = wr_col_r;
    rd_col_nxt    = rd_col_r;
    lnz_nxt       = lnz_r;
    found_nxt     = found_r;
    shift_nxt     = shift_r;
    bank_nxt      = bank_r;
    held_nxt      = held_r;
    s1_v_nxt      = res_hit;

    if (res_hit) begin
      if (rd_last) begin
        held_nxt   = 1'b0;
        rd_col_nxt = '0;
      end else begin
        rd_col_nxt = rd_col_r + 9'd1;
      end
    end

    if (wr_en) begin
      if (pix_nz) begin
        lnz_nxt   = wr_col_r;
        found_nxt = 1'b1;
      end
      if (wr_last) begin
        // Row complete: swap banks and hold it for readout.
        shift_nxt  = shift_calc;
        bank_nxt   = ~bank_r;
        held_nxt   = 1'b1;
        rd_col_nxt = '0;
        wr_col_nxt = '0;
        lnz_nxt    = '0;
        found_nxt  = 1'b0;
      end else begin
        wr_col_nxt = wr_col_r + 9'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= rsr_pkg::ROW_WIDTH_RESET;
      wr_col_r    <= '0;
      rd_col_r    <= '0;
      lnz_r       <= '0;
      found_r     <= 1'b0;
      shift_r     <= '0;
      bank_r      <= 1'b0;
      held_r      <= 1'b0;
      s1_v_r      <= 1'b0;
    end else begin
      row_width_r <= row_width_nxt;
      wr_col_r    <= wr_col_nxt;
      rd_col_r    <= rd_col_nxt;
      lnz_r       <= lnz_nxt;
      found_r     <= found_nxt;
      shift_r     <= shift_nxt;
      bank_r      <= bank_nxt;
      held_r      <= held_nxt;
      s1_v_r      <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_hit) begin
      s1_meta_r.zero    <= rd_zero;
      s1_meta_r.row_end <= rd_last;
      s1_meta_r.shifted <= (shift_r != '0);
    end
  end

  rsr_line_buf #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (rsr_pkg::PIX_W)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_pixel_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    push_data.pixel   = s1_meta_r.zero ? '0 : rd_data;
    push_data.row_end = s1_meta_r.row_end;
    push_data.shifted = s1_meta_r.shifted;
  end

  rsr_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_v_r),
    .push_data (push_data),
    .pop       (pop),
    .valid     (out_valid),
    .data      (fifo_data),
    .count     (fifo_cnt)
  );

  // Results in flight never exceed the queue depth.
  assign pop     = out_valid & out_ready;
  assign occ_sum = fifo_cnt + 2'(s1_v_r);
  assign in_ready  = (occ_sum < 2'd2) | pop;
  assign cfg_ready = 1'b1;

  assign out_pixel           = fifo_data.pixel;
  assign out_row_end         = fifo_data.row_end;
  assign out_row_was_shifted = fifo_data.shifted;

  `RSR_ASSERT(a_occ_bound, occ_sum != 2'd3, "result queue overflow")
  `RSR_ASSERT(a_read_feeds_stage, rd_en |=> s1_v_r, "line buffer read without a pending result")
  `RSR_ASSERT(a_swap_holds_row, (bank_r != $past(bank_r)) |-> held_r, "bank swap without a held row")

endmodule
